[design/torus_quasiperiodic_map_step_assert.svh]
// assertion macros shared by the torus map step rtl
`ifndef TORUS_QUASIPERIODIC_MAP_STEP_ASSERT_SVH
`define TORUS_QUASIPERIODIC_MAP_STEP_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define TQM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tqm assertion failed");

// next-cycle implication, sampled on clk, quiet during reset
`define TQM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tqm assertion failed");

`endif

[design/tqm_pkg.sv]
// types, constants and table functions for the torus map step
`timescale 1ns / 1ps
package tqm_pkg;

	typedef logic [15:0] word_t;
	typedef logic [1:0]  reg_idx_t;

	localparam reg_idx_t REG_EPSILON     = 2'd0;
	localparam reg_idx_t REG_OMEGA_THETA = 2'd1;
	localparam reg_idx_t REG_OMEGA_PSI   = 2'd2;

	localparam word_t OMEGA_THETA_RST = 16'd31829;
	localparam word_t OMEGA_PSI_RST   = 16'd59323;

	// epsilon / (2 pi) in q0.28
	localparam int EW = 28;
	localparam logic [EW-1:0] E_RST = 28'd21361416;
	localparam logic [63:0] INV2PI_Q24 = 64'd2670177;
	localparam logic [63:0] E_ROUND    = 64'd512;

	// coefficient blocks
	localparam int COEF_A1 = 0;
	localparam int COEF_A2 = 1;
	localparam int COEF_B1 = 2;
	localparam int COEF_B2 = 3;
	localparam int COEF_R  = 4;
	localparam int COEF_S  = 5;
	localparam int DEF_TERMS = 4;

	localparam word_t DEF_COEF [6][4] = '{
		'{16'd56750, 16'd35695, 16'd10214, 16'd64224},
		'{16'd2890,  16'd47021, 16'd5341,  16'd39191},
		'{16'd64583, 16'd33060, 16'd62067, 16'd15303},
		'{16'd64901, 16'd22040, 16'd19533, 16'd10162},
		'{16'd1,     16'd0,     16'd1,     16'd1},
		'{16'd0,     16'd1,     16'd1,     16'd65535}
	};

	// terms past the default set carry zero coefficients
	function automatic word_t coef_word(int kind, int term);
		word_t w;
		w = '0;
		if (term < DEF_TERMS) begin
			w = DEF_COEF[kind][term];
		end
		return w;
	endfunction

	// odd polynomial for sin over a quarter wave, q30
	localparam longint unsigned C1 = 64'd1686629713;
	localparam longint unsigned C3 = 64'd693598682;
	localparam longint unsigned C5 = 64'd85569302;
	localparam longint unsigned C7 = 64'd5026993;
	localparam longint unsigned C9 = 64'd172272;

	// quarter-wave magnitude in q0.15 for position k of 2^qpos
	function automatic logic [14:0] sine_mag(int unsigned k, int qpos);
		longint unsigned u;
		longint unsigned u2;
		longint unsigned t;
		longint unsigned sv;
		longint unsigned q;
		u  = 64'(k) << (30 - qpos);
		u2 = (u * u) >> 30;
		t  = C9;
		t  = C7 - ((u2 * t) >> 30);
		t  = C5 - ((u2 * t) >> 30);
		t  = C3 - ((u2 * t) >> 30);
		t  = C1 - ((u2 * t) >> 30);
		sv = (u * t) >> 30;
		q  = (sv + 64'd16384) >> 15;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		return q[14:0];
	endfunction

endpackage

[design/tqm_if.sv]
// stream interfaces for torus points in and mapped points out
`timescale 1ns / 1ps
interface tqm_point_if;
	logic        valid;
	logic        ready;
	logic [15:0] theta_in;
	logic [15:0] psi_in;

	modport source (output valid, output theta_in, output psi_in, input ready);
	modport sink (input valid, input theta_in, input psi_in, output ready);
endinterface

interface tqm_mapped_if;
	logic        valid;
	logic        ready;
	logic [15:0] theta_out;
	logic [15:0] psi_out;

	modport source (output valid, output theta_out, output psi_out, input ready);
	modport sink (input valid, input theta_out, input psi_out, output ready);
endinterface

[design/tqm_sine.sv]
// quarter-wave sine rom with registered read and sign restore
`timescale 1ns / 1ps
module tqm_sine #(
	parameter int SINE_ADDR_BITS = 10,
	parameter int ANGLE_BITS     = 16
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [ANGLE_BITS-1:0] phase,
	output logic signed [15:0]    sine
);
	import tqm_pkg::*;

	localparam int QP = SINE_ADDR_BITS - 2;
	localparam int IW = QP + 1;
	localparam int QN = (1 << QP) + 1;
	localparam logic [IW-1:0] QFULL = IW'(1) << QP;

	typedef logic [14:0] mag_tbl_t [QN];

	function automatic mag_tbl_t build_tbl();
		mag_tbl_t t;
		for (int k = 0; k < QN; k++) begin
			t[k] = sine_mag(k, QP);
		end
		return t;
	endfunction

	localparam mag_tbl_t MAG_TBL = build_tbl();

	logic [SINE_ADDR_BITS-1:0] adr;
	logic [IW-1:0]             idx;
	logic [14:0]               mag_s2;
	logic                      neg_s2;

	generate
		if (ANGLE_BITS >= SINE_ADDR_BITS) begin : g_trunc
			assign adr = phase[ANGLE_BITS-1 -: SINE_ADDR_BITS];
		end else begin : g_widen
			assign adr = {phase, {(SINE_ADDR_BITS - ANGLE_BITS){1'b0}}};
		end
	endgenerate

	// odd quadrants run the quarter wave backwards, the peak sits at QFULL
	assign idx = adr[QP] ? (QFULL - {1'b0, adr[QP-1:0]}) : {1'b0, adr[QP-1:0]};

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2 <= MAG_TBL[idx];
			neg_s2 <= adr[SINE_ADDR_BITS-1];
		end
	end

	assign sine = neg_s2 ? -$signed({1'b0, mag_s2}) : $signed({1'b0, mag_s2});

endmodule

[design/torus_quasiperiodic_map_step.sv]
// torus quasi-periodic map step: seven register stages, one point per cycle unless stalled
// results leave through the s7 register, one beat per cycle unless stalled
// each stage stalls only when full and blocked, so bubbles close up under back-pressure
// sine lookup uses 2*TERMS quarter-wave roms of 2^(SINE_ADDR_BITS-2)+1 entries each
// reset clears the stage valid bits and loads the default epsilon and rotations
`timescale 1ns / 1ps
`include "torus_quasiperiodic_map_step_assert.svh"
module torus_quasiperiodic_map_step #(
	parameter int TERMS          = 4,
	parameter int SINE_ADDR_BITS = 10,
	parameter int ANGLE_BITS     = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  tqm_pkg::reg_idx_t wr_index,
	input  tqm_pkg::word_t    wr_data,
	tqm_point_if.sink         point,
	tqm_mapped_if.source      mapped
);
	import tqm_pkg::*;

	localparam int AB   = ANGLE_BITS;
	localparam int UP16 = (AB >= 16) ? AB - 16 : 0;
	localparam int DN16 = (AB < 16) ? 16 - AB : 0;
	localparam int PW   = 32 + $clog2(TERMS);
	localparam int HW   = PW - 17;
	localparam int LW   = EW + 17;
	localparam int MW   = EW + 1 + HW;
	localparam int XW   = 58;
	localparam logic [XW-1:0] RND = XW'(1) << 41;

	// configuration
	logic [EW-1:0] e_q;
	word_t         om_th_q;
	word_t         om_ps_q;
	logic [EW-1:0] e_next;

	assign e_next = EW'((64'(wr_data) * INV2PI_Q24 + E_ROUND) >> 10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q     <= E_RST;
			om_th_q <= OMEGA_THETA_RST;
			om_ps_q <= OMEGA_PSI_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_EPSILON:     e_q     <= e_next;
				REG_OMEGA_THETA: om_th_q <= wr_data;
				REG_OMEGA_PSI:   om_ps_q <= wr_data;
				default: ;
			endcase
		end
	end

	// stage flow control
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	assign en7 = !v_s7 || mapped.ready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign point.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= point.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	// coordinates ride alongside for the final add
	word_t th_s1, th_s2, th_s3, th_s4, th_s5, th_s6, th_s7;
	word_t ps_s1, ps_s2, ps_s3, ps_s4, ps_s5, ps_s6, ps_s7;

	always_ff @(posedge clk) begin
		if (en1) begin
			th_s1 <= point.theta_in;
			ps_s1 <= point.psi_in;
		end
		if (en2) begin
			th_s2 <= th_s1;
			ps_s2 <= ps_s1;
		end
		if (en3) begin
			th_s3 <= th_s2;
			ps_s3 <= ps_s2;
		end
		if (en4) begin
			th_s4 <= th_s3;
			ps_s4 <= ps_s3;
		end
		if (en5) begin
			th_s5 <= th_s4;
			ps_s5 <= ps_s4;
		end
		if (en6) begin
			th_s6 <= th_s5;
			ps_s6 <= ps_s5;
		end
	end

	logic [AB-1:0] tha, psa;
	assign tha = AB'((32'(point.theta_in) << UP16) >> DN16);
	assign psa = AB'((32'(point.psi_in) << UP16) >> DN16);

	logic [AB-1:0]        ph1_s1  [TERMS];
	logic [AB-1:0]        ph2_s1  [TERMS];
	logic signed [15:0]   sine1   [TERMS];
	logic signed [15:0]   sine2   [TERMS];
	logic signed [31:0]   prod1_s3[TERMS];
	logic signed [31:0]   prod2_s3[TERMS];

	generate
		for (genvar i = 0; i < TERMS; i++) begin : g_term
			localparam word_t R16 = coef_word(COEF_R, i);
			localparam word_t S16 = coef_word(COEF_S, i);
			localparam logic [31:0] R32 = {{16{R16[15]}}, R16};
			localparam logic [31:0] S32 = {{16{S16[15]}}, S16};
			localparam logic [AB-1:0] RA = R32[AB-1:0];
			localparam logic [AB-1:0] SA = S32[AB-1:0];
			localparam logic [31:0] B1W = (32'(coef_word(COEF_B1, i)) << UP16) >> DN16;
			localparam logic [31:0] B2W = (32'(coef_word(COEF_B2, i)) << UP16) >> DN16;
			localparam logic [AB-1:0] B1A = B1W[AB-1:0];
			localparam logic [AB-1:0] B2A = B2W[AB-1:0];
			localparam logic signed [15:0] A1 = coef_word(COEF_A1, i);
			localparam logic signed [15:0] A2 = coef_word(COEF_A2, i);

			logic [AB-1:0] rs;

			// integer harmonics of the two angles, wrapping mod one turn
			assign rs = AB'(RA * tha + SA * psa);

			always_ff @(posedge clk) begin
				if (en1) begin
					ph1_s1[i] <= AB'(rs + B1A);
					ph2_s1[i] <= AB'(rs + B2A);
				end
				if (en3) begin
					prod1_s3[i] <= A1 * sine1[i];
					prod2_s3[i] <= A2 * sine2[i];
				end
			end

			tqm_sine #(
				.SINE_ADDR_BITS(SINE_ADDR_BITS),
				.ANGLE_BITS(ANGLE_BITS)
			) u_sine1 (
				.clk  (clk),
				.en   (en2),
				.phase(ph1_s1[i]),
				.sine (sine1[i])
			);

			tqm_sine #(
				.SINE_ADDR_BITS(SINE_ADDR_BITS),
				.ANGLE_BITS(ANGLE_BITS)
			) u_sine2 (
				.clk  (clk),
				.en   (en2),
				.phase(ph2_s1[i]),
				.sine (sine2[i])
			);
		end
	endgenerate

	// weighted sums, q30 fraction with 2+clog2(TERMS) integer bits
	logic signed [PW-1:0] p1_sum, p2_sum;
	logic signed [PW-1:0] p1_s4, p2_s4;

	always_comb begin
		p1_sum = '0;
		p2_sum = '0;
		for (int i = 0; i < TERMS; i++) begin
			p1_sum = p1_sum + PW'(prod1_s3[i]);
			p2_sum = p2_sum + PW'(prod2_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			p1_s4 <= p1_sum;
			p2_s4 <= p2_sum;
		end
	end

	// e * p split into a low unsigned and a high signed partial product
	logic [16:0]          p1_lo, p2_lo;
	logic signed [HW-1:0] p1_hi, p2_hi;
	logic [LW-1:0]        ml1_s5, ml2_s5;
	logic signed [MW-1:0] mh1_s5, mh2_s5;

	assign p1_lo = p1_s4[16:0];
	assign p2_lo = p2_s4[16:0];
	assign p1_hi = p1_s4[PW-1:17];
	assign p2_hi = p2_s4[PW-1:17];

	always_ff @(posedge clk) begin
		if (en5) begin
			ml1_s5 <= e_q * p1_lo;
			ml2_s5 <= e_q * p2_lo;
			mh1_s5 <= $signed({1'b0, e_q}) * p1_hi;
			mh2_s5 <= $signed({1'b0, e_q}) * p2_hi;
		end
	end

	// rounded q0.16 step, only the low bits of the product matter
	logic [XW-1:0] x1, x2;
	word_t         d1_s6, d2_s6;

	assign x1 = (XW'(mh1_s5) << 17) + XW'(ml1_s5) + RND;
	assign x2 = (XW'(mh2_s5) << 17) + XW'(ml2_s5) + RND;

	always_ff @(posedge clk) begin
		if (en6) begin
			d1_s6 <= x1[57:42];
			d2_s6 <= x2[57:42];
		end
		if (en7) begin
			th_s7 <= th_s6 + om_th_q + d1_s6;
			ps_s7 <= ps_s6 + om_ps_q + d2_s6;
		end
	end

	assign mapped.valid     = v_s7;
	assign mapped.theta_out = th_s7;
	assign mapped.psi_out   = ps_s7;

	// an accepted beat always lands in the first stage
	`TQM_ASSERT_NEXT(a_accept_fills_s1, point.valid && point.ready, v_s1)
	// a full stage that cannot advance keeps its item
	`TQM_ASSERT_NEXT(a_stall_keeps_s4, v_s4 && !en5, v_s4)
	// an item leaving the last inner stage reaches the output register
	`TQM_ASSERT_NEXT(a_s6_moves_out, v_s6 && en7, v_s7)
	// an empty output register means nothing can block the input
	`TQM_ASSERT_NOW(a_empty_out_ready, !mapped.valid, point.ready)

endmodule
